### rtl/kgw_pkg.sv
// ----------------------------------------------------------------------------
// kgw_pkg
// Shared types and codes for the keypoint grid window query block.
// ----------------------------------------------------------------------------
`default_nettype none
package kgw_pkg;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_ADD   = 2'd1,
		ACT_QUERY = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		REG_COL_SCALE = 2'd0,
		REG_ROW_SCALE = 2'd1,
		REG_ORIGIN_X  = 2'd2,
		REG_ORIGIN_Y  = 2'd3
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_BOUND,
		ST_SCAN,
		ST_ADD,
		ST_DONE
	} state_t;

	// stored keypoint: cell key is valid bit, column, row
	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [2:0]  lvl;
		logic [12:0] key;
	} entry_t;

	localparam int unsigned OPND_W  = 19;
	localparam int unsigned PROD_W  = 36;
	localparam int unsigned FRAC_W  = 20;
	localparam int unsigned STEPS   = 4;

endpackage
`default_nettype wire

### rtl/kgw_if.sv
// ----------------------------------------------------------------------------
// kgw_req_if / kgw_rsp_if
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface kgw_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic [15:0]       pos_x;
	logic [15:0]       pos_y;
	logic [2:0]        level;
	logic [15:0]       radius;
	logic [2:0]        min_level;
	logic signed [3:0] max_level;
	modport source (output valid, action, pos_x, pos_y, level, radius, min_level,
		max_level, input ready);
	modport sink (input valid, action, pos_x, pos_y, level, radius, min_level,
		max_level, output ready);
endinterface

interface kgw_rsp_if;
	logic       valid;
	logic       ready;
	logic [5:0] point_index;
	logic       hit;
	logic       in_grid;
	logic       store_full;
	logic       last;
	modport source (output valid, point_index, hit, in_grid, store_full, last,
		input ready);
	modport sink (input valid, point_index, hit, in_grid, store_full, last,
		output ready);
endinterface
`default_nettype wire

### rtl/kgw_cell.sv
// ----------------------------------------------------------------------------
// kgw_cell
// One slot of the rotating keypoint chain.
// ----------------------------------------------------------------------------
`default_nettype none
module kgw_cell (
	input  wire logic            clk,
	input  wire logic            shift,
	input  wire logic            load,
	input  wire kgw_pkg::entry_t load_data,
	input  wire kgw_pkg::entry_t nbr_data,
	output kgw_pkg::entry_t      data
);
	import kgw_pkg::*;

	entry_t entry_q;

	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= load_data;
		end else if (shift) begin
			entry_q <= nbr_data;
		end
	end

	assign data = entry_q;

endmodule
`default_nettype wire

### rtl/kgw_mult.sv
// ----------------------------------------------------------------------------
// kgw_mult
// Registered signed-by-unsigned multiplier shared by add and query setup.
// ----------------------------------------------------------------------------
`default_nettype none
module kgw_mult (
	input  wire logic                                       clk,
	input  wire logic signed [kgw_pkg::OPND_W-1:0]          a,
	input  wire logic        [15:0]                         b,
	output logic signed      [kgw_pkg::PROD_W-1:0]          prod
);
	import kgw_pkg::*;

	logic signed [16:0] b_s;

	assign b_s = signed'({1'b0, b});

	always_ff @(posedge clk) begin
		prod <= PROD_W'(a * b_s);
	end

endmodule
`default_nettype wire

### rtl/keypoint_grid_window_query.sv
// ----------------------------------------------------------------------------
// keypoint_grid_window_query
// Keypoint store on a rotating chain of cells with a grid window query.
// ----------------------------------------------------------------------------
// Clear: no result. Add: a single result, after the shared multiplier steps.
// Query: setup of 4 passes through the shared multiplier plus bounds, then
// one full chain rotation per window cell and a final result; an output
// stall freezes the rotation when a new hit meets a busy output.
// One request is handled at a time. Reset clears the point count, state and
// config registers; chain contents are unknown until written.
`default_nettype none
module keypoint_grid_window_query #(
	parameter int unsigned GRID_COLS  = 64,
	parameter int unsigned GRID_ROWS  = 48,
	parameter int unsigned MAX_POINTS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	kgw_req_if.sink          req,
	kgw_rsp_if.source        rsp,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import kgw_pkg::*;

	localparam int unsigned IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int unsigned CW = $clog2(MAX_POINTS + 1);

	state_t state_q, state_d;

	logic [15:0]        col_scale_q, row_scale_q;
	logic signed [15:0] origin_x_q, origin_y_q;

	logic [1:0]         act_q;
	logic [15:0]        qx_q, qy_q, qr_q;
	logic [2:0]         lvl_q, minl_q;
	logic signed [3:0]  maxl_q;

	logic [CW-1:0]      count_q;
	logic [2:0]         step_q;
	logic signed [PROD_W-1:0] p_q [STEPS];

	logic [5:0]         xhi_q, ylo_q, yhi_q, ix_q, iy_q;
	logic [IW-1:0]      rot_q, pend_q;
	logic               pend_v_q;

	logic               ovalid_q;
	logic [5:0]         oidx_q;
	logic               ohit_q, oing_q, ofull_q, olast_q;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_scale_q <= 16'd1024;
			row_scale_q <= 16'd1024;
			origin_x_q  <= '0;
			origin_y_q  <= '0;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_COL_SCALE: col_scale_q <= cfg_data;
				REG_ROW_SCALE: row_scale_q <= cfg_data;
				REG_ORIGIN_X:  origin_x_q  <= signed'(cfg_data);
				REG_ORIGIN_Y:  origin_y_q  <= signed'(cfg_data);
				default: ;
			endcase
		end
	end

	// shared multiplier operands
	logic signed [OPND_W-1:0] ext_x, ext_y, ext_r, ext_ox, ext_oy, m_a;
	logic [15:0]              m_b;
	logic signed [PROD_W-1:0] m_p;

	assign ext_x  = signed'({3'b000, qx_q});
	assign ext_y  = signed'({3'b000, qy_q});
	assign ext_r  = signed'({3'b000, qr_q});
	assign ext_ox = OPND_W'(origin_x_q);
	assign ext_oy = OPND_W'(origin_y_q);

	always_comb begin
		m_a = ext_x - ext_ox - ext_r;
		m_b = col_scale_q;
		if (act_q == ACT_ADD) begin
			m_a = step_q[0] ? ext_y : ext_x;
			m_b = step_q[0] ? row_scale_q : col_scale_q;
		end else begin
			case (step_q[1:0])
				2'd0: begin m_a = ext_x - ext_ox - ext_r; m_b = col_scale_q; end
				2'd1: begin m_a = ext_x - ext_ox + ext_r; m_b = col_scale_q; end
				2'd2: begin m_a = ext_y - ext_oy - ext_r; m_b = row_scale_q; end
				default: begin m_a = ext_y - ext_oy + ext_r; m_b = row_scale_q; end
			endcase
		end
	end

	kgw_mult u_mult (.clk(clk), .a(m_a), .b(m_b), .prod(m_p));

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL && step_q != 3'd0) begin
			p_q[2'(step_q - 3'd1)] <= m_p;
		end
	end

	// window bounds: floor on the low side, ceil on the high side
	localparam logic [PROD_W-1:0] CEIL_ADD = PROD_W'((1 << FRAC_W) - 1);
	localparam logic signed [15:0] COL_MAX = 16'(GRID_COLS - 1);
	localparam logic signed [15:0] ROW_MAX = 16'(GRID_ROWS - 1);
	logic signed [PROD_W-1:0] cx1_s, cy1_s;
	logic signed [15:0] x0, x1, y0, y1, x0c, x1c, y0c, y1c;
	logic               win_ok;

	assign cx1_s = (p_q[1] + signed'(CEIL_ADD)) >>> FRAC_W;
	assign cy1_s = (p_q[3] + signed'(CEIL_ADD)) >>> FRAC_W;

	always_comb begin
		x0 = p_q[0][FRAC_W+15:FRAC_W];
		y0 = p_q[2][FRAC_W+15:FRAC_W];
		x1 = cx1_s[15:0];
		y1 = cy1_s[15:0];
		x0c = (x0 < 0) ? 16'sd0 : x0;
		y0c = (y0 < 0) ? 16'sd0 : y0;
		x1c = (x1 > COL_MAX) ? COL_MAX : x1;
		y1c = (y1 > ROW_MAX) ? ROW_MAX : y1;
		win_ok = (x0c <= x1c) && (y0c <= y1c);
	end

	// add: rounded cell
	localparam logic [PROD_W-1:0] HALF = PROD_W'(1 << (FRAC_W - 1));
	logic [PROD_W-1:0] ax_s, ay_s;
	logic [15:0]       acx, acy;
	logic              add_ing, add_full;

	assign ax_s     = unsigned'(p_q[0]) + HALF;
	assign ay_s     = unsigned'(p_q[1]) + HALF;
	assign acx      = ax_s[FRAC_W+15:FRAC_W];
	assign acy      = ay_s[FRAC_W+15:FRAC_W];
	assign add_ing  = (acx < 16'(GRID_COLS)) && (acy < 16'(GRID_ROWS));
	assign add_full = (count_q >= CW'(MAX_POINTS));

	// chain of cells, head at index 0
	entry_t cell_d [MAX_POINTS];
	entry_t new_entry, head;
	logic   chain_shift, chain_load;

	always_comb begin
		new_entry.x   = qx_q;
		new_entry.y   = qy_q;
		new_entry.lvl = lvl_q;
		new_entry.key = add_ing ? {1'b1, acx[5:0], acy[5:0]} : 13'd0;
	end

	for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
		kgw_cell u_cell (
			.clk       (clk),
			.shift     (chain_shift),
			.load      (chain_load && (count_q == CW'(i))),
			.load_data (new_entry),
			.nbr_data  (cell_d[(i + 1) % MAX_POINTS]),
			.data      (cell_d[i])
		);
	end

	assign head = cell_d[0];

	// head match
	logic [16:0] dx, dy;
	logic        lvl_ok, hit_now, out_free, stall;
	logic        rot_last, row_last, col_last;

	always_comb begin
		dx = {1'b0, head.x} - {1'b0, qx_q};
		dy = {1'b0, head.y} - {1'b0, qy_q};
		if (dx[16]) dx = -dx;
		if (dy[16]) dy = -dy;
		lvl_ok = (head.lvl >= minl_q) && (maxl_q[3] || (head.lvl <= maxl_q[2:0]));
	end

	assign hit_now  = (CW'(rot_q) < count_q) && (head.key == {1'b1, ix_q, iy_q}) &&
		lvl_ok && (dx < {1'b0, qr_q}) && (dy < {1'b0, qr_q});
	assign out_free = !ovalid_q || rsp.ready;
	assign stall    = hit_now && pend_v_q && !out_free;
	assign rot_last = (rot_q == IW'(MAX_POINTS - 1));
	assign row_last = (iy_q == yhi_q);
	assign col_last = (ix_q == xhi_q);

	// control
	logic       emit;
	logic [5:0] e_idx;
	logic       e_hit, e_ing, e_full, e_last;

	always_comb begin
		state_d     = state_q;
		chain_shift = 1'b0;
		chain_load  = 1'b0;
		emit        = 1'b0;
		e_idx       = '0;
		e_hit       = 1'b0;
		e_ing       = 1'b0;
		e_full      = 1'b0;
		e_last      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					if (req.action == ACT_ADD || req.action == ACT_QUERY) state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (step_q == 3'(STEPS)) state_d = (act_q == ACT_ADD) ? ST_ADD : ST_BOUND;
			end
			ST_BOUND: begin
				state_d = win_ok ? ST_SCAN : ST_DONE;
			end
			ST_SCAN: begin
				if (!stall) begin
					chain_shift = 1'b1;
					if (hit_now && pend_v_q) begin
						emit  = 1'b1;
						e_idx = 6'(pend_q);
						e_hit = 1'b1;
					end
					if (rot_last && row_last && col_last) state_d = ST_DONE;
				end
			end
			ST_ADD: begin
				if (out_free) begin
					emit   = 1'b1;
					e_last = 1'b1;
					if (add_full) begin
						e_full = 1'b1;
					end else begin
						chain_load = 1'b1;
						e_idx      = 6'(count_q);
						e_hit      = 1'b1;
						e_ing      = add_ing;
					end
					state_d = ST_IDLE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					emit    = 1'b1;
					e_last  = 1'b1;
					e_hit   = pend_v_q;
					e_idx   = pend_v_q ? 6'(pend_q) : 6'd0;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign req.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			step_q   <= '0;
			rot_q    <= '0;
			pend_v_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && req.valid && req.action == ACT_CLEAR) begin
				count_q <= '0;
			end
			if (chain_load) count_q <= count_q + 1'b1;
			step_q <= (state_q == ST_MUL) ? step_q + 3'd1 : 3'd0;
			if (state_q == ST_SCAN && !stall) begin
				rot_q <= rot_last ? '0 : rot_q + 1'b1;
				if (hit_now) pend_v_q <= 1'b1;
			end
			if (state_q == ST_DONE && out_free) pend_v_q <= 1'b0;
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// request capture, window walk and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			act_q  <= req.action;
			qx_q   <= req.pos_x;
			qy_q   <= req.pos_y;
			qr_q   <= req.radius;
			lvl_q  <= req.level;
			minl_q <= req.min_level;
			maxl_q <= req.max_level;
		end
		if (state_q == ST_BOUND) begin
			xhi_q <= x1c[5:0];
			ylo_q <= y0c[5:0];
			yhi_q <= y1c[5:0];
			ix_q  <= x0c[5:0];
			iy_q  <= y0c[5:0];
		end
		if (state_q == ST_SCAN && !stall) begin
			if (hit_now) pend_q <= rot_q;
			// advance row inside column, column after last row
			if (rot_last) begin
				if (row_last) begin
					iy_q <= ylo_q;
					if (!col_last) ix_q <= ix_q + 6'd1;
				end else begin
					iy_q <= iy_q + 6'd1;
				end
			end
		end
		if (emit) begin
			oidx_q  <= e_idx;
			ohit_q  <= e_hit;
			oing_q  <= e_ing;
			ofull_q <= e_full;
			olast_q <= e_last;
		end
	end

	assign rsp.valid       = ovalid_q;
	assign rsp.point_index = oidx_q;
	assign rsp.hit         = ohit_q;
	assign rsp.in_grid     = oing_q;
	assign rsp.store_full  = ofull_q;
	assign rsp.last        = olast_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_POINTS))
		else $error("point count beyond store depth");

	a_chain_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (rot_q == '0))
		else $error("chain not aligned when idle");

	a_full_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD && out_free && add_full) |=> (count_q == $past(count_q)))
		else $error("full store changed on add");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result overwrote a pending result");

endmodule
`default_nettype wire
